// ===== rtl/hsbl_pkg.sv =====
// Shared types and constants for the letter-count heap sorter.
`timescale 1ns / 1ps
package hsbl_pkg;
    localparam logic [7:0] LETTER_A = 8'h61;
    localparam int unsigned IDX_W = 6;
    localparam int unsigned OUT_COUNT_W = 10;

    // Memory commands from the controller to the datapath.
    typedef enum logic [1:0] {
        CMD_NONE,
        CMD_RD,
        CMD_WR_A,
        CMD_WR_B
    } t_mem_cmd;

    typedef struct packed {
        t_mem_cmd         mem;
        logic [IDX_W-1:0] addr;
        logic             load_a;
        logic             load_b;
    } t_dp_ctrl;
endpackage

// ===== rtl/hsbl_datapath.sv =====
// Datapath: key/index store memory, string loader and two swap registers.
`timescale 1ns / 1ps
module hsbl_datapath #(
    parameter int unsigned MAX_STRINGS = 64,
    parameter int unsigned COUNT_BITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_sym_beat,
    input  logic [7:0]                  i_symbol,
    input  logic                        i_eos,
    input  logic                        i_total_full,
    input  logic [hsbl_pkg::IDX_W-1:0]  i_total_addr,
    input  hsbl_pkg::t_dp_ctrl          i_ctrl,
    output logic [COUNT_BITS-1:0]       o_key_a,
    output logic [COUNT_BITS-1:0]       o_key_b,
    output logic [COUNT_BITS-1:0]       o_key_rd,
    output logic [hsbl_pkg::IDX_W-1:0]  o_idx_a
);
    import hsbl_pkg::*;
    localparam int unsigned EW = COUNT_BITS + IDX_W;
    logic [EW-1:0] r_mem [MAX_STRINGS];
    logic [EW-1:0] r_rd;
    logic [EW-1:0] r_a;
    logic [EW-1:0] r_b;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;

    always_comb begin
        n_count = r_count;
        if (i_symbol == LETTER_A && r_count != {COUNT_BITS{1'b1}}) begin
            n_count = r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            if (i_sym_beat) begin
                r_count <= i_eos ? '0 : n_count;
            end
        end
    end

    // The read port runs every cycle; A and B take the read data on command.
    always_ff @(posedge i_clk) begin
        r_rd <= r_mem[i_ctrl.addr];
        if (i_sym_beat && i_eos && !i_total_full) begin
            r_mem[i_total_addr] <= {n_count, i_total_addr};
        end else if (i_ctrl.mem == CMD_WR_A) begin
            r_mem[i_ctrl.addr] <= r_a;
        end else if (i_ctrl.mem == CMD_WR_B) begin
            r_mem[i_ctrl.addr] <= r_b;
        end
        if (i_ctrl.load_a) r_a <= r_rd;
        if (i_ctrl.load_b) r_b <= r_rd;
    end

    assign o_key_a  = r_a[EW-1:IDX_W];
    assign o_key_b  = r_b[EW-1:IDX_W];
    assign o_key_rd = r_rd[EW-1:IDX_W];
    assign o_idx_a  = r_a[IDX_W-1:0];
endmodule

// ===== rtl/hsbl_ctrl.sv =====
// Controller: heap build, sift-down sequencing and result emission.
`timescale 1ns / 1ps
module hsbl_ctrl #(
    parameter int unsigned COUNT_BITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [hsbl_pkg::IDX_W:0]    i_total,
    input  logic [COUNT_BITS-1:0]       i_key_a,
    input  logic [COUNT_BITS-1:0]       i_key_b,
    input  logic [COUNT_BITS-1:0]       i_key_rd,
    input  logic                        i_out_ready,
    output hsbl_pkg::t_dp_ctrl          o_ctrl,
    output logic                        o_busy,
    output logic                        o_out_valid,
    output logic                        o_out_last,
    output logic                        o_done
);
    import hsbl_pkg::*;
    // A holds the entry being sifted, B the largest child found so far.
    typedef enum logic [3:0] {
        S_IDLE, S_BUILD, S_RD_NODE, S_LD_NODE, S_RD_LEFT, S_LD_LEFT, S_CMP_RIGHT,
        S_MOVE, S_EXTRACT, S_X_RD_ROOT, S_X_RD_LAST, S_X_LD_LAST, S_EMIT_RD,
        S_EMIT_LD, S_EMIT
    } t_state;

    t_state             r_state;
    logic [IDX_W:0]     r_n;
    logic [IDX_W:0]     r_total;
    logic [IDX_W:0]     r_k;
    logic [IDX_W-1:0]   r_node;
    logic [IDX_W-1:0]   r_big;
    logic               r_build;
    logic               r_valid;
    logic               r_last;
    logic               r_done;
    logic [IDX_W+1:0]   w_left;
    logic [IDX_W+1:0]   w_right;
    logic               w_has_left;
    logic               w_has_right;
    logic [COUNT_BITS-1:0] w_big_key;
    t_dp_ctrl           w_ctrl;

    assign w_left      = {1'b0, r_node, 1'b1};
    assign w_right     = w_left + 1'b1;
    assign w_has_left  = (w_left < {1'b0, r_n});
    assign w_has_right = (w_right < {1'b0, r_n});
    assign w_big_key   = (r_big == r_node) ? i_key_a : i_key_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_last  <= 1'b0;
            r_done  <= 1'b0;
            r_n <= '0; r_total <= '0; r_k <= '0; r_node <= '0; r_big <= '0;
            r_build <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_total <= i_total;
                        r_n     <= i_total;
                        r_k     <= i_total >> 1;
                        r_build <= 1'b1;
                        r_state <= S_BUILD;
                    end
                end
                S_BUILD: begin
                    if (r_k == '0) begin
                        r_build <= 1'b0;
                        r_k     <= r_total;
                        r_state <= S_EXTRACT;
                    end else begin
                        r_node  <= IDX_W'(r_k - 1'b1);
                        r_k     <= r_k - 1'b1;
                        r_state <= S_RD_NODE;
                    end
                end
                S_RD_NODE: r_state <= S_LD_NODE;
                S_LD_NODE: r_state <= S_RD_LEFT;
                S_RD_LEFT: begin
                    if (w_has_left) begin
                        r_state <= S_LD_LEFT;
                    end else begin
                        r_big   <= r_node;
                        r_state <= S_MOVE;
                    end
                end
                S_LD_LEFT: begin
                    // The left child wins only when strictly larger than the node.
                    r_big   <= (i_key_a < i_key_rd) ? IDX_W'(w_left) : r_node;
                    r_state <= w_has_right ? S_CMP_RIGHT : S_MOVE;
                end
                S_CMP_RIGHT: begin
                    if (w_big_key < i_key_rd) r_big <= IDX_W'(w_right);
                    r_state <= S_MOVE;
                end
                S_MOVE: begin
                    if (r_big == r_node) begin
                        r_state <= r_build ? S_BUILD : S_EXTRACT;
                    end else begin
                        r_node  <= r_big;
                        r_state <= S_RD_LEFT;
                    end
                end
                S_EXTRACT: begin
                    // Swap root with entry k-1, then sift the root over k-1 entries.
                    if (r_k <= (IDX_W+1)'(1)) begin
                        r_k     <= '0;
                        r_state <= S_EMIT_RD;
                    end else begin
                        r_k     <= r_k - 1'b1;
                        r_n     <= r_k - 1'b1;
                        r_node  <= '0;
                        r_state <= S_X_RD_ROOT;
                    end
                end
                S_X_RD_ROOT: r_state <= S_X_RD_LAST;
                S_X_RD_LAST: r_state <= S_X_LD_LAST;
                S_X_LD_LAST: r_state <= S_RD_LEFT;
                S_EMIT_RD:   r_state <= S_EMIT_LD;
                S_EMIT_LD: begin
                    r_valid <= 1'b1;
                    r_last  <= (r_k + 1'b1 == r_total);
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (i_out_ready) begin
                        r_valid <= 1'b0;
                        if (r_last) begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_EMIT_RD;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath commands decoded from the state; read data is registered and valid in
    // the cycle after the address is presented.
    always_comb begin
        w_ctrl     = '0;
        w_ctrl.mem = CMD_NONE;
        unique case (r_state)
            S_RD_NODE: begin
                w_ctrl.mem  = CMD_RD;
                w_ctrl.addr = r_node;
            end
            S_LD_NODE: w_ctrl.load_a = 1'b1;
            S_RD_LEFT: begin
                if (w_has_left) begin
                    w_ctrl.mem  = CMD_RD;
                    w_ctrl.addr = IDX_W'(w_left);
                end
            end
            S_LD_LEFT: begin
                w_ctrl.load_b = (i_key_a < i_key_rd);
                if (w_has_right) begin
                    w_ctrl.mem  = CMD_RD;
                    w_ctrl.addr = IDX_W'(w_right);
                end
            end
            S_CMP_RIGHT: w_ctrl.load_b = (w_big_key < i_key_rd);
            S_MOVE: begin
                w_ctrl.mem  = (r_big == r_node) ? CMD_WR_A : CMD_WR_B;
                w_ctrl.addr = r_node;
            end
            S_X_RD_ROOT: begin
                w_ctrl.mem  = CMD_RD;
                w_ctrl.addr = '0;
            end
            S_X_RD_LAST: begin
                w_ctrl.load_b = 1'b1;
                w_ctrl.mem    = CMD_RD;
                w_ctrl.addr   = r_n[IDX_W-1:0];
            end
            S_X_LD_LAST: begin
                w_ctrl.load_a = 1'b1;
                w_ctrl.mem    = CMD_WR_B;
                w_ctrl.addr   = r_n[IDX_W-1:0];
            end
            S_EMIT_RD: begin
                w_ctrl.mem  = CMD_RD;
                w_ctrl.addr = r_k[IDX_W-1:0];
            end
            S_EMIT_LD: w_ctrl.load_a = 1'b1;
            default: ;
        endcase
    end

    assign o_ctrl      = w_ctrl;
    assign o_busy      = (r_state != S_IDLE);
    assign o_out_valid = r_valid;
    assign o_out_last  = r_last;
    assign o_done      = r_done;
endmodule

// ===== rtl/heap_sort_by_letter_count_core.sv =====
// Top level of the letter-count heap sorter.
// After the end_of_set beat the heap is built, then extracted in place, then emitted.
// Flow: one character beat per cycle while loading; the input is held off while
// sorting and emitting, and each result beat is read, loaded and then emitted.
// Reset: synchronous, active low; clears the counters, the string total and the controller.
`timescale 1ns / 1ps
module heap_sort_by_letter_count_core #(
    parameter int unsigned MAX_STRINGS = 64,
    parameter int unsigned COUNT_BITS = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // symbol[7:0]
    input  logic        s_axis_tlast,   // end_of_string
    input  logic        s_axis_tuser,   // end_of_set
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // string_index[5:0], letter_count[15:6]
    output logic        m_axis_tlast    // last
);
    import hsbl_pkg::*;
    localparam int unsigned AW = IDX_W;

    logic [AW:0] r_total;
    logic        w_beat;
    logic        w_eos;
    logic        w_busy;
    logic        w_done;
    logic        w_start;
    t_dp_ctrl    w_ctrl;
    logic [COUNT_BITS-1:0] w_key_a;
    logic [COUNT_BITS-1:0] w_key_b;
    logic [COUNT_BITS-1:0] w_key_rd;
    logic [5:0]  w_idx_a;
    logic        r_sorting;

    assign s_axis_tready = !r_sorting;
    assign w_beat = s_axis_tvalid && s_axis_tready;
    assign w_eos  = s_axis_tlast || s_axis_tuser;
    assign w_start = w_beat && s_axis_tuser;

    // String count stops at the store size; extra strings are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total   <= '0;
            r_sorting <= 1'b0;
        end else begin
            if (w_done) begin
                r_total   <= '0;
                r_sorting <= 1'b0;
            end else if (w_beat && w_eos && r_total != (AW+1)'(MAX_STRINGS)) begin
                r_total <= r_total + 1'b1;
            end
            if (w_start) r_sorting <= 1'b1;
        end
    end

    logic [AW:0] w_total_next;
    assign w_total_next = (r_total != (AW+1)'(MAX_STRINGS)) ? r_total + 1'b1 : r_total;

    hsbl_datapath #(.MAX_STRINGS(MAX_STRINGS), .COUNT_BITS(COUNT_BITS)) u_dp (
        .i_clk, .i_rst_n,
        .i_sym_beat  (w_beat),
        .i_symbol    (s_axis_tdata),
        .i_eos       (w_eos),
        .i_total_full(r_total == (AW+1)'(MAX_STRINGS)),
        .i_total_addr(r_total[AW-1:0]),
        .i_ctrl      (w_ctrl),
        .o_key_a     (w_key_a),
        .o_key_b     (w_key_b),
        .o_key_rd    (w_key_rd),
        .o_idx_a     (w_idx_a)
    );

    hsbl_ctrl #(.COUNT_BITS(COUNT_BITS)) u_ctrl (
        .i_clk, .i_rst_n,
        .i_start    (w_start),
        .i_total    (w_total_next),
        .i_key_a    (w_key_a),
        .i_key_b    (w_key_b),
        .i_key_rd   (w_key_rd),
        .i_out_ready(m_axis_tready),
        .o_ctrl     (w_ctrl),
        .o_busy     (w_busy),
        .o_out_valid(m_axis_tvalid),
        .o_out_last (m_axis_tlast),
        .o_done     (w_done)
    );

    assign m_axis_tdata = {OUT_COUNT_W'(w_key_a), w_idx_a};

`ifndef SYNTHESIS
    a_no_input_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_busy |-> !s_axis_tready) else $error("input taken during sort");
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= (AW+1)'(MAX_STRINGS)) else $error("string total overflow");
    a_valid_only_sorting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> r_sorting) else $error("result outside sort");
`endif
endmodule

// ===== tb/heap_sort_by_letter_count_core_tb.sv =====
// Testbench for the letter-count heap sorter: random strings, scoreboard check of sorted output.
`timescale 1ns / 1ps
module heap_sort_by_letter_count_core_tb;
    import hsbl_pkg::*;

    localparam int unsigned MAX_STR = 64;
    localparam int unsigned CNT_W = 10;
    localparam logic [CNT_W-1:0] CNT_SAT = {CNT_W{1'b1}};
    localparam longint LIMIT_CYCLES = 3000000;

    typedef struct packed {
        logic [IDX_W-1:0]       idx;
        logic [OUT_COUNT_W-1:0] cnt;
        logic                   last;
    } t_sorted_beat;

    // Scoreboard: keeps its own copy of the string store and the running count,
    // and queues the sorted beats each end of set produces.
    class sort_scoreboard;
        logic [CNT_W-1:0] keys[MAX_STR];
        logic [IDX_W-1:0] idxs[MAX_STR];
        logic [CNT_W-1:0] run_cnt;
        int unsigned      total;
        t_sorted_beat     pending[$];
        int unsigned      errors;
        int unsigned      beats_seen;
        int unsigned      sets_done;

        function new();
            run_cnt = '0;
            total = 0;
            errors = 0;
            beats_seen = 0;
            sets_done = 0;
        endfunction

        function void swap_pair(int unsigned p, int unsigned q);
            logic [CNT_W-1:0] tk;
            logic [IDX_W-1:0] ti;
            tk = keys[p]; keys[p] = keys[q]; keys[q] = tk;
            ti = idxs[p]; idxs[p] = idxs[q]; idxs[q] = ti;
        endfunction

        // Max-heap sift: left child wins only if strictly larger, then right likewise.
        function void sift(int unsigned node, int unsigned n);
            int unsigned l, r, big;
            forever begin
                l = 2 * node + 1;
                r = l + 1;
                big = node;
                if (l < n && keys[big] < keys[l]) big = l;
                if (r < n && keys[big] < keys[r]) big = r;
                if (big == node) break;
                swap_pair(big, node);
                node = big;
            end
        endfunction

        function void note_char(logic [7:0] sym, logic eos, logic eoset);
            int unsigned k;
            if (sym == LETTER_A && run_cnt != CNT_SAT) run_cnt++;
            if (!(eos || eoset)) return;
            if (total < MAX_STR) begin
                keys[total] = run_cnt;
                idxs[total] = total[IDX_W-1:0];
                total++;
            end
            run_cnt = '0;
            if (!eoset) return;
            for (k = total / 2; k > 0; k--) sift(k - 1, total);
            for (k = total; k > 1; k--) begin
                swap_pair(0, k - 1);
                sift(0, k - 1);
            end
            for (k = 0; k < total; k++)
                pending.push_back('{idxs[k], keys[k][OUT_COUNT_W-1:0], k + 1 == total});
            total = 0;
            sets_done++;
        endfunction

        function void check_beat(logic [15:0] data, logic last);
            t_sorted_beat want;
            beats_seen++;
            if (pending.size() == 0) begin
                $error("unexpected result beat: tdata=%h tlast=%b", data, last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (data[5:0] !== want.idx) begin
                $error("string_index: expected %0d, got %0d", want.idx, data[5:0]);
                errors++;
            end
            if (data[15:6] !== want.cnt) begin
                $error("letter_count: expected %0d, got %0d", want.cnt, data[15:6]);
                errors++;
            end
            if (last !== want.last) begin
                $error("last: expected %b, got %b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tlast;

    sort_scoreboard sb = new();
    longint cycle_count = 0;
    bit     sink_quiet = 1'b0;
    int unsigned chars_sent = 0;

    always #5 i_clk = ~i_clk;

    heap_sort_by_letter_count_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls (none while sink_quiet), sampled at the handshake edge.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_beat(m_axis_tdata, m_axis_tlast);
        if (sink_quiet) m_axis_tready <= 1'b1;
        else m_axis_tready <= ($urandom_range(0, 99) < 70);
    end

    always @(posedge i_clk) begin
        if (cycle_count > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("heap_sort_by_letter_count_core_tb failed");
            $finish;
        end
    end

    // Drives one character beat and waits for its acceptance.
    task automatic send_char(logic [7:0] sym, logic eos, logic eoset);
        int unsigned g;
        g = gap_len();
        repeat (g) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= sym;
        s_axis_tlast <= eos;
        s_axis_tuser <= eoset;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_char(sym, eos, eoset);
        chars_sent++;
    endtask

    task automatic idle_sender();
        s_axis_tvalid <= 1'b0;
    endtask

    // One string of given length; about half its bytes are 'a' when dense.
    task automatic send_string(int unsigned len, bit dense, bit ends_set);
        logic [7:0] sym;
        int unsigned k;
        for (k = 0; k < len; k++) begin
            if (dense ? $urandom_range(0, 1) : ($urandom_range(0, 7) == 0)) sym = LETTER_A;
            else sym = 8'($urandom_range(0, 255));
            send_char(sym, k + 1 == len && !(ends_set && $urandom_range(0, 1)),
                      ends_set && k + 1 == len);
        end
    endtask

    // Stops sending and waits until every expected sorted beat is back.
    task automatic drain();
        idle_sender();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    initial begin
        int unsigned k, nstr;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single-character set, extreme bytes, equal keys, set end alone.
        send_char(8'h00, 1'b1, 1'b1);
        send_char(LETTER_A, 1'b0, 1'b0);
        send_char(8'hFF, 1'b1, 1'b0);
        send_char(LETTER_A, 1'b1, 1'b0);
        send_char(8'h60, 1'b1, 1'b0);
        send_char(8'h62, 1'b0, 1'b0);
        send_char(8'hE1, 1'b0, 1'b1);
        send_char(LETTER_A, 1'b0, 1'b0);
        send_char(LETTER_A, 1'b0, 1'b0);
        send_char(8'h55, 1'b1, 1'b0);
        send_char(8'hAA, 1'b1, 1'b0);
        send_char(LETTER_A, 1'b1, 1'b1);
        // Pause until every sorted beat is back before going on.
        drain();

        // Full store: 70 strings, the last six dropped, with the sink always ready.
        sink_quiet = 1'b1;
        for (k = 0; k < 70; k++) send_string($urandom_range(1, 2), 1'b1, k == 69);
        drain();
        sink_quiet = 1'b0;

        // Random small sets.
        while (chars_sent < 210) begin
            nstr = $urandom_range(1, 8);
            for (k = 0; k < nstr; k++)
                send_string($urandom_range(1, 4), $urandom_range(0, 1), k + 1 == nstr);
        end
        drain();
        repeat (50) @(posedge i_clk);

        $display("Covered %0d character beats in %0d sets, %0d sorted beats checked.",
                 chars_sent, sb.sets_done, sb.beats_seen);
        $display("Included a full store with dropped strings, a set ending alone and equal keys.");
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("heap_sort_by_letter_count_core_tb passed");
        end else begin
            $display("heap_sort_by_letter_count_core_tb failed");
        end
        $finish;
    end
endmodule
